>>> rtl/min_distance_symbol_demapper_assert.svh
// Assertion macros shared by the checker of the symbol demapper.
// Each macro needs i_clk in scope; the first two also need i_rst_n.
`ifndef MIN_DISTANCE_SYMBOL_DEMAPPER_ASSERT_SVH
`define MIN_DISTANCE_SYMBOL_DEMAPPER_ASSERT_SVH

`define MDSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("demapper check failed");

`define MDSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("demapper check failed");

`define MDSD_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("demapper reset check failed");

`endif

>>> rtl/mdsd_pkg.sv
// Package of the minimum-distance symbol demapper: payload types, queue
// command type, state type and fixed widths. No dependencies.
package mdsd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = 6;
    localparam int TABLE_MAX   = 64;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int SQ_W        = 2 * SAMPLE_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int LEVEL_HALF  = 1 << (SAMPLE_W - 4);
    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_BINARY,
        MODE_QPSK,
        MODE_QAM16,
        MODE_QAM64
    } t_mode;

    typedef enum logic [0:0] {
        FUNC_LOAD,
        FUNC_DEMAP
    } t_func;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_DIRECT,
        CMD_SEARCH
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_DRAIN,
        B_DONE
    } t_bstate;

    typedef struct packed {
        t_func                       func;
        logic [IDX_W-1:0]            point_index;
        logic signed [SAMPLE_W-1:0]  sample_i;
        logic signed [SAMPLE_W-1:0]  sample_q;
        logic                        sample_last;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] symbol_index;
        logic             block_last;
    } t_out_item;

    typedef struct packed {
        t_kind                       kind;
        logic [IDX_W-1:0]            index;
        logic signed [SAMPLE_W-1:0]  si;
        logic signed [SAMPLE_W-1:0]  sq;
        logic                        last;
        logic [IDX_W-1:0]            sym;
        logic [IDX_W-1:0]            limit;
    } t_cmd;

endpackage

>>> rtl/min_distance_symbol_demapper.sv
// Top level of the minimum-distance hard-decision symbol demapper.
// Instantiates mdsd_front, mdsd_fifo and mdsd_back; depends on mdsd_pkg.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-------------------------
//   input   | in        | i_valid / o_stall     | i_data (t_in_item)
//   result  | out       | o_valid / i_stall     | o_data (t_out_item)
//   config  | in        | i_cfg_we              | i_cfg_data (mode)
//
// A load item or a binary-mode decision is handled while the back end is idle.
// A search runs the single distance unit over the table, one table entry per cycle,
// through the read, difference, square and compare registers, then hands over the
// result; limit + 1 points (4, 16 or 64, capped by MAX_POINTS) are searched, limit being the last index.
// Reset clears the queue, the sequencer and the result valid; tables are not cleared.
// A stalled result holds direct decisions and a search's hand-over; the queue takes new transfers until full.
module min_distance_symbol_demapper #(
    parameter int MAX_POINTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mdsd_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output mdsd_pkg::t_out_item o_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_data
);
    import mdsd_pkg::*;

    t_mode r_mode;
    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    t_cmd  front_cmd;
    t_cmd  head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BINARY;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    mdsd_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_data  (i_data),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (r_mode),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    mdsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    mdsd_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

>>> rtl/mdsd_front.sv
// Front end of the demapper: accepts input items and turns them into queue
// commands (load, direct decision, or table search). Depends on mdsd_pkg.
module mdsd_front #(
    parameter int MAX_POINTS = 64
) (
    input  mdsd_pkg::t_in_item i_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  mdsd_pkg::t_mode    i_mode,
    input  logic               i_full,
    output logic               o_push,
    output mdsd_pkg::t_cmd     o_cmd
);
    import mdsd_pkg::*;

    localparam logic [IDX_W-1:0] LIM =
        (MAX_POINTS >= TABLE_MAX) ? IDX_W'(TABLE_MAX - 1) : IDX_W'(MAX_POINTS - 1);
    localparam logic signed [SAMPLE_W-1:0] HALF = SAMPLE_W'(LEVEL_HALF);

    logic             keep;
    logic [IDX_W-1:0] sel;

    always_comb begin
        keep        = 1'b1;
        sel         = '0;
        o_cmd.kind  = CMD_SEARCH;
        o_cmd.index = i_data.point_index;
        o_cmd.si    = i_data.sample_i;
        o_cmd.sq    = i_data.sample_q;
        o_cmd.last  = i_data.sample_last;
        o_cmd.sym   = (i_data.sample_i > HALF) ? IDX_W'(0) : IDX_W'(1);
        case (i_mode)
            MODE_BINARY: begin
                o_cmd.kind = CMD_DIRECT;
            end
            MODE_QPSK: begin
                sel = IDX_W'(3);
            end
            MODE_QAM16: begin
                sel = IDX_W'(15);
            end
            MODE_QAM64: begin
                sel = IDX_W'(63);
            end
            default: begin
                o_cmd.kind = CMD_DIRECT;
            end
        endcase
        o_cmd.limit = (sel > LIM) ? LIM : sel;
        if (i_data.func == FUNC_LOAD) begin
            o_cmd.kind = CMD_LOAD;
            keep       = (32'(i_data.point_index) < MAX_POINTS);
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && keep;

endmodule

>>> rtl/mdsd_fifo.sv
// Short command queue between the front end and the search back end.
// Depends on mdsd_pkg for the command type and the queue depth.
module mdsd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mdsd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output mdsd_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import mdsd_pkg::*;

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QA_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/mdsd_back.sv
// Back end of the demapper: point tables, the shared pipelined distance unit
// with its search sequencer, and the output register. Depends on mdsd_pkg.
module mdsd_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  mdsd_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output mdsd_pkg::t_out_item o_data
);
    import mdsd_pkg::*;

    localparam int DEPTH = (MAX_POINTS < TABLE_MAX) ? MAX_POINTS : TABLE_MAX;
    localparam int AW    = $clog2(DEPTH);

    t_bstate r_state;
    t_bstate n_state;

    logic signed [SAMPLE_W-1:0] r_pt_i [DEPTH];
    logic signed [SAMPLE_W-1:0] r_pt_q [DEPTH];

    logic [IDX_W-1:0]           r_k;
    logic [IDX_W-1:0]           r_limit;
    logic signed [SAMPLE_W-1:0] r_si;
    logic signed [SAMPLE_W-1:0] r_sq;
    logic                       r_last;

    logic signed [SAMPLE_W-1:0] r_rd_i;
    logic signed [SAMPLE_W-1:0] r_rd_q;
    logic                       r_v1;
    logic [IDX_W-1:0]           r_k1;
    logic                       r_l1;

    logic signed [DIFF_W-1:0]   r_di;
    logic signed [DIFF_W-1:0]   r_dq;
    logic                       r_v2;
    logic [IDX_W-1:0]           r_k2;
    logic                       r_l2;

    logic [SQ_W-1:0]            r_sqi;
    logic [SQ_W-1:0]            r_sqq;
    logic                       r_v3;
    logic [IDX_W-1:0]           r_k3;
    logic                       r_l3;

    logic [SUM_W-1:0]           r_best;
    logic [IDX_W-1:0]           r_sym;

    logic                       r_out_valid;
    t_out_item                  r_out;

    logic                       out_free;
    logic                       mem_we;
    logic                       start;
    logic                       issue;
    logic                       load_direct;
    logic                       load_done;
    logic signed [2*DIFF_W-1:0] prod_i;
    logic signed [2*DIFF_W-1:0] prod_q;
    logic [SUM_W-1:0]           sum;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty && i_cmd.kind == CMD_SEARCH) begin
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (r_k == r_limit) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: begin
                if (r_v3 && r_l3) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        start       = 1'b0;
        issue       = 1'b0;
        load_direct = 1'b0;
        load_done   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.kind)
                        CMD_LOAD: begin
                            o_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        CMD_DIRECT: begin
                            if (out_free) begin
                                o_pop       = 1'b1;
                                load_direct = 1'b1;
                            end
                        end
                        CMD_SEARCH: begin
                            o_pop = 1'b1;
                            start = 1'b1;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_RUN: begin
                issue = 1'b1;
            end
            B_DONE: begin
                load_done = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pt_i[i_cmd.index[AW-1:0]] <= i_cmd.si;
            r_pt_q[i_cmd.index[AW-1:0]] <= i_cmd.sq;
        end
        if (issue) begin
            r_rd_i <= r_pt_i[r_k[AW-1:0]];
            r_rd_q <= r_pt_q[r_k[AW-1:0]];
        end
    end

    assign prod_i = r_di * r_di;
    assign prod_q = r_dq * r_dq;
    assign sum    = {1'b0, r_sqi} + {1'b0, r_sqq};

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_si    <= i_cmd.si;
            r_sq    <= i_cmd.sq;
            r_last  <= i_cmd.last;
            r_limit <= i_cmd.limit;
        end
        r_k1  <= r_k;
        r_l1  <= (r_k == r_limit);
        r_di  <= {r_si[SAMPLE_W-1], r_si} - {r_rd_i[SAMPLE_W-1], r_rd_i};
        r_dq  <= {r_sq[SAMPLE_W-1], r_sq} - {r_rd_q[SAMPLE_W-1], r_rd_q};
        r_k2  <= r_k1;
        r_l2  <= r_l1;
        r_sqi <= prod_i[SQ_W-1:0];
        r_sqq <= prod_q[SQ_W-1:0];
        r_k3  <= r_k2;
        r_l3  <= r_l2;
        if (r_v3 && (r_k3 == '0 || sum < r_best)) begin
            r_best <= sum;
            r_sym  <= r_k3;
        end
        if (load_direct) begin
            r_out.symbol_index <= i_cmd.sym;
            r_out.block_last   <= i_cmd.last;
        end else if (load_done) begin
            r_out.symbol_index <= r_sym;
            r_out.block_last   <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_k <= '0;
            end else if (issue) begin
                r_k <= r_k + 1'b1;
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (load_direct || load_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> rtl/mdsd_checker.sv
// Port-level checker of the symbol demapper and its bind to the top level.
// Depends on mdsd_pkg and min_distance_symbol_demapper_assert.svh.
`include "min_distance_symbol_demapper_assert.svh"

module mdsd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input mdsd_pkg::t_out_item o_data
);
    import mdsd_pkg::*;

    `MDSD_ASSERT_NEXT(a_result_held, o_valid && i_stall, o_valid && $stable(o_data))
    `MDSD_ASSERT_SAME(a_stall_after_transfer, $rose(o_stall), $past(i_valid && !o_stall))
    `MDSD_ASSERT_RESET(a_reset_no_result, !i_rst_n, !o_valid)
    `MDSD_ASSERT_RESET(a_reset_queue_open, !i_rst_n, !o_stall)

endmodule

bind min_distance_symbol_demapper mdsd_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
